// ===== src/isrt_pkg.sv =====
// ----------------------------------------------------------------------------
// isrt_pkg: shared types and constants for the insertion sorter
// Store depth, value width and the control word passed down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package isrt_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IO_WIDTH    = 32;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [IO_WIDTH-1:0]    io_value_t;

    // one command word, broadcast to every cell
    typedef struct packed {
        logic insert;   // place the incoming value, shift larger ones up
        logic shift;    // move every cell down by one place
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/isrt_cell.sv =====
// ----------------------------------------------------------------------------
// isrt_cell: one place of the sorted store
// Holds one value; on insert takes the new value or its lower neighbour's,
// on shift takes its upper neighbour's.
// ----------------------------------------------------------------------------
`default_nettype none

module isrt_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire isrt_pkg::cell_ctrl_t ctrl,
    input  wire isrt_pkg::value_t    ins_value,
    input  wire isrt_pkg::value_t    prev_value,
    input  wire logic                prev_valid,
    input  wire logic                prev_gt,
    input  wire isrt_pkg::value_t    next_value,
    input  wire logic                next_valid,
    output isrt_pkg::value_t         value,
    output logic                     valid,
    output logic                     gt
);
    import isrt_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;

    // an empty place counts as larger than anything
    assign gt = !valid_reg || (value_reg > ins_value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctrl.insert && gt)
        begin
            value_next = prev_gt ? prev_value : ins_value;
            valid_next = valid_reg | prev_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ===== src/insertion_sorter_top.sv =====
// Latency: first result is offered the cycle after the last item's transfer.
// Throughput: one item per cycle while collecting; a run of N values then
//   drains one per cycle while out_ready is high, input held off.
// The rate is set by the cell chain: every cell compares and shifts at once.
// Reset: asynchronous, active low; clears all valid bits, overflow and drain.
// ----------------------------------------------------------------------------
// insertion_sorter_top: stable insertion sorter on a chain of cells
// Values enter one per transfer into an ascending chain; the item flagged
// last triggers a drain of the whole chain in order, cell 0 first.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter_top (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire isrt_pkg::io_value_t   value,
    input  wire logic                  last_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output isrt_pkg::io_value_t        sorted_value,
    output logic                       last_result,
    output logic                       overflow
);
    import isrt_pkg::*;

    value_t     cell_value [MAX_ITEMS];
    logic       cell_valid [MAX_ITEMS];
    logic       cell_gt    [MAX_ITEMS];
    cell_ctrl_t ctrl;
    value_t     ins_value;

    logic drain_reg;
    logic drain_next;
    logic ovf_reg;
    logic ovf_next;
    logic in_xfer;
    logic out_xfer;
    logic full;

    // hold off input while a run drains; cell 0 is the output register
    assign in_ready = !drain_reg;
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // store full once the top cell is occupied
    assign full = cell_valid[MAX_ITEMS-1];

    // resize to the store width, sign extending where it grows
    assign ins_value = VALUE_WIDTH'(value);

    assign ctrl.insert = in_xfer && !full;
    assign ctrl.shift  = out_xfer;

    always_comb
    begin
        drain_next = drain_reg;
        ovf_next   = ovf_reg;
        if (in_xfer)
        begin
            // drop the value if no room is left, and remember it
            if (full)
                ovf_next = 1'b1;
            if (last_item)
                drain_next = 1'b1;
        end
        if (out_xfer && last_result)
        begin
            drain_next = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            drain_reg <= drain_next;
            ovf_reg   <= ovf_next;
        end
    end

    // cell chain: cell 0 holds the smallest value
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        value_t prev_value;
        logic   prev_valid;
        logic   prev_gt;
        value_t next_value;
        logic   next_valid;

        if (i == 0)
        begin : g_first
            // below the first cell: always occupied, never larger
            assign prev_value = ins_value;
            assign prev_valid = 1'b1;
            assign prev_gt    = 1'b0;
        end
        else
        begin : g_mid
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_gt    = cell_gt[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_top
            assign next_value = cell_value[i];
            assign next_valid = 1'b0;
        end
        else
        begin : g_low
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
        end

        isrt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .ins_value  (ins_value),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .prev_gt    (prev_gt),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .gt         (cell_gt[i])
        );
    end

    // a drain always starts with cell 0 occupied; the run ends at the
    // last occupied cell
    assign out_valid    = drain_reg;
    assign sorted_value = IO_WIDTH'(cell_value[0]);
    assign last_result  = !cell_valid[1];
    assign overflow     = ovf_reg;

endmodule

`default_nettype wire

// ===== src/isrt_checker.sv =====
// ----------------------------------------------------------------------------
// isrt_checker: port-level checks for the insertion sorter
// Watches the handshakes and the ordering of the drained run.
// ----------------------------------------------------------------------------
`default_nettype none

module isrt_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic                last_item,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire isrt_pkg::io_value_t sorted_value,
    input  wire logic                last_result
);
    import isrt_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sorted_value))
        else $error("stalled result changed");

    // input is held off while a run drains
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken during drain");

    // the transfer of the last item starts a drain
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_item |=> out_valid)
        else $error("no result after last item");

    // the run ends exactly after the flagged result
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> (out_valid == !$past(last_result)))
        else $error("run length wrong");

    // results come in ascending order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_result |=>
            sorted_value >= $past(sorted_value))
        else $error("results out of order");

endmodule

bind insertion_sorter_top isrt_checker u_isrt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .last_result  (last_result)
);

`default_nettype wire

// ===== tb/tb_insertion_sorter_top.sv =====
// ----------------------------------------------------------------------------
// tb_insertion_sorter_top: self-checking bench for the insertion sorter
// Sends sets of signed values with the final one flagged. A queue-based
// sorting model predicts each drained run, including full-store drops and
// the overflow flag. The monitor checks every output transfer against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_insertion_sorter_top;

    import isrt_pkg::*;

    localparam int RANDOM_ITEMS      = 310;   // random part stops past this count
    localparam int LONG_HOLD_AT      = 60;    // input transfers before the long stall
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES       = 20;
    localparam int WATCHDOG_LIMIT    = 5000;  // cycles with no transfer on either side

    // receiver back-pressure patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_ALTERNATE
    } rx_pattern_e;

    typedef struct {
        io_value_t value;
        bit        last;
        bit        drain_first;   // hold until every expected result has come
    } sort_item_t;

    typedef struct {
        io_value_t sorted_value;
        bit        last_result;
        bit        overflow;
    } sorted_result_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    io_value_t value = '0;
    logic      last_item = 1'b0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    io_value_t sorted_value;
    logic      last_result;
    logic      overflow;

    insertion_sorter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .last_result  (last_result),
        .overflow     (overflow)
    );

    // items waiting to be offered, and runs predicted but not yet seen
    sort_item_t     pending_items[$];
    sorted_result_t expected_results[$];

    // sorting model state: ascending values held, and whether one was dropped
    io_value_t held_values[$];
    bit        held_overflow = 1'b0;

    int sent_count  = 0;     // items put on the input (driver side)
    int taken_count = 0;     // items transferred (monitor side)
    int idle_cycles = 0;
    int fail_count  = 0;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall shaping
    rx_pattern_e rx_pattern   = RX_ALWAYS;
    int          pattern_left = 0;
    int          long_hold_left = 0;
    bit          long_hold_done = 1'b0;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hold reset, then release it away from the rising edge.
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Driver: present a new item at the falling edge once the previous one has
    // been transferred. Work in bursts with random gaps; an item marked
    // drain_first waits until the sorter has returned everything expected.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_input
        sort_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && taken_count != sent_count)
        begin
            // hold the current item until it is taken
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else if (pending_items.size() != 0 &&
                 !(pending_items[0].drain_first && expected_results.size() != 0))
        begin
            item = pending_items.pop_front();
            in_valid  <= 1'b1;
            value     <= item.value;
            last_item <= item.last;
            sent_count++;
            if (burst_left <= 1)
            begin
                // new burst; now and then a long one with no gaps at all
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            else
            begin
                burst_left--;
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: change stall pattern at random intervals. Once, after
    // LONG_HOLD_AT input transfers, hold off for a long stretch so that a
    // pending drain backs up and the input stalls.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (!long_hold_done && taken_count >= LONG_HOLD_AT)
            begin
                long_hold_left = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (pattern_left == 0)
            begin
                rx_pattern   = rx_pattern_e'($urandom_range(0, 3));
                pattern_left = $urandom_range(16, 96);
            end
            else
            begin
                pattern_left--;
            end

            if (long_hold_left != 0)
            begin
                long_hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_pattern)
                    RX_ALWAYS:    out_ready <= 1'b1;
                    RX_RANDOM:    out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:    out_ready <= ($urandom_range(0, 3) == 0);
                    RX_ALTERNATE: out_ready <= ~out_ready;
                    default:      out_ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Check the output
    // transfer first, so a result can never be matched against an expectation
    // raised by an input in the same cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : observe
        sorted_result_t want;
        int             pos;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: sorted_value %0d last_result %0b overflow %0b",
                           sorted_value, last_result, overflow);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (sorted_value !== want.sorted_value)
                    begin
                        $error("sorted_value: expected %0d, got %0d",
                               want.sorted_value, sorted_value);
                        fail_count++;
                    end
                    if (last_result !== want.last_result)
                    begin
                        $error("last_result: expected %0b, got %0b",
                               want.last_result, last_result);
                        fail_count++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", want.overflow, overflow);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                taken_count++;
                // insert after every held value that is not larger: keeps ties stable
                if (held_values.size() < MAX_ITEMS)
                begin
                    pos = held_values.size();
                    while (pos > 0 && held_values[pos-1] > value)
                        pos--;
                    held_values.insert(pos, value);
                end
                else
                begin
                    held_overflow = 1'b1;
                end

                // the flagged item releases the whole store in order
                if (last_item)
                begin
                    foreach (held_values[k])
                    begin
                        want.sorted_value = held_values[k];
                        want.last_result  = (k == held_values.size() - 1);
                        want.overflow     = held_overflow;
                        expected_results.push_back(want);
                    end
                    held_values.delete();
                    held_overflow = 1'b0;
                end
            end

            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Abort when neither channel has moved for too long.
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("** insertion_sorter_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        sort_item_t item;
        int         n_random;
        int         set_len;
        int         set_kind;
        int         value_style;
        io_value_t  repeat_value;
        bit         mid_drain_done;

        n_random       = 0;
        mid_drain_done = 1'b0;
        item.drain_first = 1'b0;

        // Directed: extremes of both signs, zero, all-ones and duplicates;
        // between them every bit of the value sees both levels.
        item.last = 1'b0;
        item.value = 32'sh7FFF_FFFF; pending_items.push_back(item);
        item.value = 32'sh8000_0000; pending_items.push_back(item);
        item.value = 32'sh0000_0000; pending_items.push_back(item);
        item.value = -32'sd1;        pending_items.push_back(item);
        item.value = 32'sd1;         pending_items.push_back(item);
        item.value = 32'sh0000_0000; pending_items.push_back(item);
        item.value = 32'sh8000_0000; pending_items.push_back(item);
        item.value = 32'sh7FFF_FFFF; pending_items.push_back(item);
        item.last = 1'b1;
        item.value = 32'sd5;         pending_items.push_back(item);

        // a set of one item: the flagged item alone
        item.value = -32'sd7;        pending_items.push_back(item);

        // descending input: every insert shifts the whole store
        item.last = 1'b0;
        for (int k = 4; k >= -1; k--)
        begin
            item.value = io_value_t'(k);
            item.last  = (k == -1);
            pending_items.push_back(item);
        end

        // ascending input: no shifting at all
        for (int k = 1; k <= 3; k++)
        begin
            item.value = io_value_t'(k * 10);
            item.last  = (k == 3);
            pending_items.push_back(item);
        end

        // Random sets. Mostly short ones; some fill the store exactly or
        // overrun it (the flagged item itself may then be dropped); a few are
        // runs of one repeated value.
        while (n_random < RANDOM_ITEMS)
        begin
            set_kind    = $urandom_range(0, 99);
            value_style = $urandom_range(0, 2);
            if (set_kind < 65)
                set_len = $urandom_range(1, 10);
            else if (set_kind < 85)
                set_len = $urandom_range(11, MAX_ITEMS - 1);
            else if (set_kind < 95)
                set_len = $urandom_range(MAX_ITEMS, MAX_ITEMS + 3);
            else
                set_len = $urandom_range(1, 4);
            repeat_value = io_value_t'($urandom);

            for (int k = 0; k < set_len; k++)
            begin
                if (set_kind >= 95)
                    item.value = repeat_value;
                else if (value_style == 0)
                    item.value = io_value_t'($urandom);
                else if (value_style == 1)
                    item.value = io_value_t'($urandom_range(0, 8)) - 32'sd4;   // many ties
                else
                    case ($urandom_range(0, 4))
                        0: item.value = 32'sh7FFF_FFFF;
                        1: item.value = 32'sh8000_0000;
                        2: item.value = 32'sh0000_0000;
                        3: item.value = -32'sd1;
                        default: item.value = io_value_t'($urandom);
                    endcase
                item.last = (k == set_len - 1);

                // pause the sender until everything has drained: once at the
                // start of the random part and once at a set boundary midway
                item.drain_first = (n_random == 0) ||
                                   (k == 0 && !mid_drain_done && n_random > RANDOM_ITEMS / 2);
                if (item.drain_first && n_random != 0)
                    mid_drain_done = 1'b1;

                pending_items.push_back(item);
                n_random++;
            end
        end

        // wait until every item is taken and every result has come back
        @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        // leave room for any stray output after the last result
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("** insertion_sorter_top: PASSED **");
        else
            $display("** insertion_sorter_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== insertion_sorter_top.f =====
src/isrt_pkg.sv
src/isrt_cell.sv
src/insertion_sorter_top.sv
src/isrt_checker.sv
tb/tb_insertion_sorter_top.sv
